### rtl/assert_macros.svh
// Assertion macros for the RTL of the latest-frame buffer pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lfbp_pkg.sv
// Types and codes of the latest-frame buffer pool.
package lfbp_pkg;

	localparam int OP_W   = 3;
	localparam int SLOT_W = 4;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [1:0]        status_t;

	localparam op_t OP_CLAIM   = 3'd0;
	localparam op_t OP_FINISH  = 3'd1;
	localparam op_t OP_ABORT   = 3'd2;
	localparam op_t OP_ACQUIRE = 3'd3;
	localparam op_t OP_RELEASE = 3'd4;

	localparam status_t ST_FREE    = 2'd0;
	localparam status_t ST_WRITING = 2'd1;
	localparam status_t ST_READY   = 2'd2;
	localparam status_t ST_READING = 2'd3;

endpackage

### rtl/latest_frame_buffer_pool.sv
// Latest-frame buffer pool: slot status registers, operation decode and result register.
//
// One producer and one consumer share SLOTS buffer slots. Each request on the
// req channel carries an operation (claim write, finish write, abort write,
// acquire latest, release read) and a slot index; each request gives exactly
// one response on the rsp channel with ok and the granted slot in slot_out.
// Both channels use valid and ready; a transfer happens when both are high.
//
// A request is captured in an input register, then decoded and applied to the
// slot status registers as its response is loaded into the output register;
// this happens once the output register is empty or its response is taken.
// One request can be taken every cycle while the receiver keeps rsp_ready high.
//
// When the receiver holds rsp_ready low, the response stays in the output
// register, one more request waits in the input register, and req_ready
// drops until the response is taken. Reset sets every slot free, clears the
// latest-ready pointer and empties both registers.
module latest_frame_buffer_pool #(
	parameter int SLOTS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [lfbp_pkg::OP_W-1:0]   operation,
	input  logic [lfbp_pkg::SLOT_W-1:0] slot,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       ok,
	output logic [lfbp_pkg::SLOT_W-1:0] slot_out
);
	import lfbp_pkg::*;

	`include "assert_macros.svh"

	localparam logic [SLOT_W:0] SlotCount = (SLOT_W + 1)'(SLOTS);

	// Input register.
	logic      valid_s1;
	op_t       op_s1;
	slot_idx_t slot_s1;

	// Pool state.
	status_t [SLOTS-1:0] status_q;
	logic                latest_valid_q;
	slot_idx_t           latest_index_q;

	// Output register.
	logic      rsp_valid_q;
	logic      ok_q;
	slot_idx_t slot_out_q;

	logic                advance;
	status_t [SLOTS-1:0] status_d;
	logic                latest_valid_d;
	slot_idx_t           latest_index_d;
	logic                ok_d;
	slot_idx_t           grant_d;
	logic [SLOTS-1:0]    free_vec;
	logic [SLOTS-1:0]    first_free;
	logic [SLOTS-1:0]    ready_vec;
	slot_idx_t           free_idx;
	status_t             st_req;
	status_t             st_latest;
	logic                req_in_range;
	logic                latest_in_range;
	logic                pointed_ready;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	assign rsp_valid = rsp_valid_q;
	assign ok        = ok_q;
	assign slot_out  = slot_out_q;

	// Per-slot views of the status registers.
	always_comb begin
		free_vec  = '0;
		ready_vec = '0;
		st_req    = ST_FREE;
		st_latest = ST_FREE;
		free_idx  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i]  = (status_q[i] == ST_FREE);
			ready_vec[i] = (status_q[i] == ST_READY);
			if (slot_s1 == SLOT_W'(i)) begin
				st_req = st_req | status_q[i];
			end
			if (latest_index_q == SLOT_W'(i)) begin
				st_latest = st_latest | status_q[i];
			end
		end
		// Isolate the lowest free slot, then encode it.
		first_free = free_vec & (~free_vec + SLOTS'(1));
		for (int i = 0; i < SLOTS; i++) begin
			if (first_free[i]) begin
				free_idx = free_idx | SLOT_W'(i);
			end
		end
	end

	assign req_in_range    = {1'b0, slot_s1} < SlotCount;
	assign latest_in_range = {1'b0, latest_index_q} < SlotCount;
	assign pointed_ready   = latest_valid_q && latest_in_range && (st_latest == ST_READY);

	// Next state and response for the request in the input register.
	always_comb begin
		status_d       = status_q;
		latest_valid_d = latest_valid_q;
		latest_index_d = latest_index_q;
		ok_d           = 1'b0;
		grant_d        = '0;
		unique case (op_s1)
			OP_CLAIM: begin
				if (|free_vec) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (first_free[i]) begin
							status_d[i] = ST_WRITING;
						end
					end
					ok_d    = 1'b1;
					grant_d = free_idx;
				end else if (pointed_ready) begin
					// No free slot: the stale ready frame is overwritten.
					for (int i = 0; i < SLOTS; i++) begin
						if (latest_index_q == SLOT_W'(i)) begin
							status_d[i] = ST_WRITING;
						end
					end
					latest_valid_d = 1'b0;
					ok_d           = 1'b1;
					grant_d        = latest_index_q;
				end
			end
			OP_FINISH: begin
				if (req_in_range && st_req == ST_WRITING) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_s1 == SLOT_W'(i)) begin
							status_d[i] = ST_READY;
						end else if (pointed_ready && latest_index_q == SLOT_W'(i)) begin
							status_d[i] = ST_FREE;
						end
					end
					latest_index_d = slot_s1;
					latest_valid_d = 1'b1;
					ok_d           = 1'b1;
				end
			end
			OP_ABORT: begin
				if (req_in_range && st_req == ST_WRITING) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_s1 == SLOT_W'(i)) begin
							status_d[i] = ST_FREE;
						end
					end
					ok_d = 1'b1;
				end
			end
			OP_ACQUIRE: begin
				if (latest_valid_q && latest_in_range) begin
					if (st_latest == ST_READY) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (latest_index_q == SLOT_W'(i)) begin
								status_d[i] = ST_READING;
							end
						end
						ok_d    = 1'b1;
						grant_d = latest_index_q;
					end
					latest_valid_d = 1'b0;
				end
			end
			OP_RELEASE: begin
				if (req_in_range && st_req == ST_READING) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (slot_s1 == SLOT_W'(i)) begin
							status_d[i] = ST_FREE;
						end
					end
					ok_d = 1'b1;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			op_s1   <= operation;
			slot_s1 <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q       <= {SLOTS{ST_FREE}};
			latest_valid_q <= 1'b0;
			latest_index_q <= '0;
		end else if (advance) begin
			status_q       <= status_d;
			latest_valid_q <= latest_valid_d;
			latest_index_q <= latest_index_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q       <= ok_d;
			slot_out_q <= grant_d;
		end
	end

	// At most one frame is ready, and it is the one the pointer names.
	`ASSERT_ALWAYS(a_one_ready, clk, arst_n,
		$countones(ready_vec) == int'(latest_valid_q), "ready slots disagree with pointer")
	`ASSERT_IMPLIES(a_ptr_ready, clk, arst_n, latest_valid_q,
		pointed_ready, "valid pointer names a slot that is not ready")
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(op_s1) && $stable(slot_s1), "stalled request was lost")
	`ASSERT_NEXT(a_rsp_load, clk, arst_n, advance,
		rsp_valid_q, "processed request gave no response")
	`ASSERT_IMPLIES(a_reject_zero, clk, arst_n, rsp_valid_q && !ok_q,
		slot_out_q == '0, "rejected response carries a slot")

endmodule

### tb/sv/latest_frame_buffer_pool_tb.sv
// Self-checking testbench of the latest-frame buffer pool.
module latest_frame_buffer_pool_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lfbp_pkg::*;

	localparam int SLOTS       = 4;
	localparam int RSP_LATENCY = 2;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 1900;
	localparam int IDLE_PCT    = 20;

	// Operation codes the block does not define; each must be rejected.
	localparam op_t OP_NONE5 = 3'd5;
	localparam op_t OP_NONE6 = 3'd6;
	localparam op_t OP_NONE7 = 3'd7;

	typedef struct packed {
		logic      ok;
		slot_idx_t slot_out;
	} pool_rsp_t;

	typedef struct packed {
		op_t       op;
		slot_idx_t slot;
		logic      typed;
		logic      exp_ok;
		slot_idx_t exp_slot;
	} req_row_t;

	// Rows with typed set carry the answer; the rest take the predicted one.
	localparam req_row_t DIRECTED_ROWS [0:22] = '{
		'{OP_ACQUIRE, 4'd0,  1'b1, 1'b0, 4'd0},
		'{OP_RELEASE, 4'd0,  1'b1, 1'b0, 4'd0},
		'{OP_FINISH,  4'd15, 1'b1, 1'b0, 4'd0},
		'{OP_ABORT,   4'd0,  1'b1, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b1, 1'b1, 4'd0},
		'{OP_CLAIM,   4'd15, 1'b0, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_FINISH,  4'd1,  1'b0, 1'b0, 4'd0},
		'{OP_FINISH,  4'd2,  1'b0, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_CLAIM,   4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_ABORT,   4'd2,  1'b0, 1'b0, 4'd0},
		'{OP_FINISH,  4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_ACQUIRE, 4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_ACQUIRE, 4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_RELEASE, 4'd0,  1'b0, 1'b0, 4'd0},
		'{OP_RELEASE, 4'd4,  1'b1, 1'b0, 4'd0},
		'{OP_ABORT,   4'd15, 1'b1, 1'b0, 4'd0},
		'{OP_NONE5,   4'd0,  1'b1, 1'b0, 4'd0},
		'{OP_NONE6,   4'd0,  1'b1, 1'b0, 4'd0},
		'{OP_NONE7,   4'd15, 1'b1, 1'b0, 4'd0}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	op_t       operation = OP_CLAIM;
	slot_idx_t slot      = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	logic      ok;
	slot_idx_t slot_out;

	status_t   pool_status [SLOTS];
	logic      latest_vld;
	slot_idx_t latest_slot;
	pool_rsp_t pending_rsp [$];
	int        mismatch_cnt = 0;
	int        stall_cycles = 0;
	bit        quiet = 1'b0;

	latest_frame_buffer_pool #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.slot     (slot),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ok       (ok),
		.slot_out (slot_out)
	);

	always #4 clk = ~clk;

	// Applies one operation to the pool as the block should, returning its response.
	function automatic pool_rsp_t apply_pool_op(input op_t op, input slot_idx_t s);
		pool_rsp_t r;
		bit        in_rng;
		bit        latest_rdy;
		r = '0;
		in_rng = s < SLOTS;
		latest_rdy = latest_vld && latest_slot < SLOTS && pool_status[latest_slot] == ST_READY;
		case (op)
			OP_CLAIM: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!r.ok && pool_status[i] == ST_FREE) begin
						pool_status[i] = ST_WRITING;
						r.ok = 1'b1;
						r.slot_out = slot_idx_t'(i);
					end
				end
				// With nothing free, the stale ready frame is taken back.
				if (!r.ok && latest_rdy) begin
					pool_status[latest_slot] = ST_WRITING;
					latest_vld = 1'b0;
					r.ok = 1'b1;
					r.slot_out = latest_slot;
				end
			end
			OP_FINISH: begin
				if (in_rng && pool_status[s] == ST_WRITING) begin
					if (latest_rdy && latest_slot != s)
						pool_status[latest_slot] = ST_FREE;
					pool_status[s] = ST_READY;
					latest_slot = s;
					latest_vld = 1'b1;
					r.ok = 1'b1;
				end
			end
			OP_ABORT: begin
				if (in_rng && pool_status[s] == ST_WRITING) begin
					pool_status[s] = ST_FREE;
					r.ok = 1'b1;
				end
			end
			OP_ACQUIRE: begin
				if (latest_vld && latest_slot < SLOTS) begin
					if (pool_status[latest_slot] == ST_READY) begin
						pool_status[latest_slot] = ST_READING;
						r.ok = 1'b1;
						r.slot_out = latest_slot;
					end
					latest_vld = 1'b0;
				end
			end
			OP_RELEASE: begin
				if (in_rng && pool_status[s] == ST_READING) begin
					pool_status[s] = ST_FREE;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Mostly legal producer and consumer steps, with some arbitrary requests mixed in.
	function automatic void pick_pool_req(output op_t op, output slot_idx_t s);
		slot_idx_t writing [$];
		slot_idx_t reading [$];
		for (int i = 0; i < SLOTS; i++) begin
			if (pool_status[i] == ST_WRITING)
				writing.push_back(slot_idx_t'(i));
			if (pool_status[i] == ST_READING)
				reading.push_back(slot_idx_t'(i));
		end
		s = slot_idx_t'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 15) begin
			op = op_t'($urandom_range(0, 7));
			return;
		end
		op = op_t'($urandom_range(OP_CLAIM, OP_RELEASE));
		case (op)
			OP_FINISH, OP_ABORT: begin
				s = writing.size() ? writing[$urandom_range(0, writing.size() - 1)]
				                   : slot_idx_t'($urandom_range(0, SLOTS - 1));
			end
			OP_RELEASE: begin
				s = reading.size() ? reading[$urandom_range(0, reading.size() - 1)]
				                   : slot_idx_t'($urandom_range(0, SLOTS - 1));
			end
			default: ;
		endcase
	endfunction

	// Drives one request from a falling edge and returns at the falling edge after its transfer.
	task automatic send_pool_req(input op_t op, input slot_idx_t s, input bit typed,
	                             input pool_rsp_t typed_rsp);
		pool_rsp_t predicted;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		slot <= s;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = apply_pool_op(op, s);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			rsp_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
	end

	always @(posedge clk) begin
		pool_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected: ok=%0b slot_out=%0d",
				         $time, ok, slot_out);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (ok !== want.ok) begin
					$display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, ok);
					mismatch_cnt++;
				end
				if (slot_out !== want.slot_out) begin
					$display("%0t: slot_out mismatch: expected %0d, actual %0d",
					         $time, want.slot_out, slot_out);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		op_t       op;
		slot_idx_t s;
		for (int i = 0; i < SLOTS; i++)
			pool_status[i] = ST_FREE;
		latest_vld = 1'b0;
		latest_slot = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (DIRECTED_ROWS[i])
			send_pool_req(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].slot, DIRECTED_ROWS[i].typed,
			              '{DIRECTED_ROWS[i].exp_ok, DIRECTED_ROWS[i].exp_slot});
		for (int n = 0; n < RAND_ITEMS; n++) begin
			// A stretch in the middle runs both channels at full rate.
			quiet = n >= 700 && n < 1000;
			pick_pool_req(op, s);
			send_pool_req(op, s, 1'b0, '0);
		end
		quiet = 1'b0;
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (RSP_LATENCY + 6) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/lfbp_pkg.sv
rtl/latest_frame_buffer_pool.sv
tb/sv/latest_frame_buffer_pool_tb.sv
